### src/bmhq_pkg.sv
// shared constants, codes and types of the binary min-heap queue
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int ID_BITS_DEF  = 20;
  localparam int KEY_BITS_DEF = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CMP,
    ST_POP_LAST,
    ST_POP_CMP,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

### src/binary_min_heap_queue.sv
// top level of the binary min-heap priority queue with its output register
`timescale 1ns / 1ps

// Binary min-heap of (id, key) entries in a CAPACITY-deep RAM with one
// result transaction for every input transaction: push (tuser 0) or pop of
// the minimum (tuser 1). Ties leave in heap order: a push stops below a
// parent with an equal key, a pop takes the right child only when strictly
// smaller. A push on a full heap or a pop on an empty one is refused with a
// status and changes nothing. One operation is in flight at a time. A push
// climbs one level at a time and a pop sinks one level at a time, the
// sift loop doing one RAM read-compare-write per heap level; the root is
// mirrored in registers so it costs no RAM read. The result waits in an
// output register, so the next input is taken while it is pending.
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // entry_id, entry_key
  input  logic [((ID_BITS+KEY_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // popped_id, popped_key, entries_held, root_valid, root_key
  output logic [((ID_BITS+2*KEY_BITS+$clog2(CAPACITY+1)+1+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0] m_axis_tuser
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY+1);
  localparam int EW    = ID_BITS + KEY_BITS;

  logic                res_valid;
  logic                res_ready;
  logic [ID_BITS-1:0]  res_pid;
  logic [KEY_BITS-1:0] res_pkey;
  logic [1:0]          res_status;
  logic [CW-1:0]       res_count;
  logic                res_root_valid;
  logic [KEY_BITS-1:0] res_root_key;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr_a;
  logic [AW-1:0]       ram_raddr_b;
  logic [EW-1:0]       ram_rdata_a;
  logic [EW-1:0]       ram_rdata_b;

  logic [ID_BITS-1:0]  out_pid;
  logic [KEY_BITS-1:0] out_pkey;
  logic [1:0]          out_status;
  logic [CW-1:0]       out_count;
  logic                out_root_valid;
  logic [KEY_BITS-1:0] out_root_key;

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  bmhq_ctrl #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .KEY_BITS (KEY_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_op          (s_axis_tuser),
    .in_id          (s_axis_tdata[ID_BITS-1:0]),
    .in_key         (s_axis_tdata[EW-1:ID_BITS]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_pid        (res_pid),
    .res_pkey       (res_pkey),
    .res_status     (res_status),
    .res_count      (res_count),
    .res_root_valid (res_root_valid),
    .res_root_key   (res_root_key),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr_a    (ram_raddr_a),
    .ram_raddr_b    (ram_raddr_b),
    .ram_rdata_a    (ram_rdata_a),
    .ram_rdata_b    (ram_rdata_b)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_pid        <= res_pid;
      out_pkey       <= res_pkey;
      out_status     <= res_status;
      out_count      <= res_count;
      out_root_valid <= res_root_valid;
      out_root_key   <= res_root_key;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[ID_BITS-1:0]                     = out_pid;
    m_axis_tdata[EW-1:ID_BITS]                    = out_pkey;
    m_axis_tdata[EW+CW-1:EW]                      = out_count;
    m_axis_tdata[EW+CW]                           = out_root_valid;
    m_axis_tdata[EW+CW+KEY_BITS:EW+CW+1]          = out_root_key;
  end

  assign m_axis_tuser = out_status;

endmodule

### src/bmhq_ram.sv
// heap storage: one write port, two read ports, registered read data
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### src/bmhq_ctrl.sv
// sift sequencer: reads, compares and writes back heap entries level by level
`timescale 1ns / 1ps

module bmhq_ctrl
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int ID_BITS  = ID_BITS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [ID_BITS-1:0]            in_id,
  input  logic [KEY_BITS-1:0]           in_key,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [ID_BITS-1:0]            res_pid,
  output logic [KEY_BITS-1:0]           res_pkey,
  output logic [1:0]                    res_status,
  output logic [$clog2(CAPACITY+1)-1:0] res_count,
  output logic                          res_root_valid,
  output logic [KEY_BITS-1:0]           res_root_key,
  output logic                          ram_we,
  output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
  output logic [ID_BITS+KEY_BITS-1:0]   ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr_a,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr_b,
  input  logic [ID_BITS+KEY_BITS-1:0]   ram_rdata_a,
  input  logic [ID_BITS+KEY_BITS-1:0]   ram_rdata_b
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int PW = CW + 1;
  localparam int EW = ID_BITS + KEY_BITS;

  state_t state, state_next;

  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  logic [ID_BITS-1:0]  cur_id;
  logic [KEY_BITS-1:0] cur_key;
  logic [ID_BITS-1:0]  pid;
  logic [KEY_BITS-1:0] pkey;
  logic [1:0]          status;
  logic [ID_BITS-1:0]  root_id;
  logic [KEY_BITS-1:0] root_key;

  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic [CW-1:0]       count_m1;
  logic [AW-1:0]       up;
  logic [AW-1:0]       up_parent;
  logic [KEY_BITS-1:0] key_a;
  logic [KEY_BITS-1:0] key_b;
  logic                push_stop;
  logic [PW-1:0]       lft;
  logic [PW-1:0]       rgt;
  logic                pick_right;
  logic [PW-1:0]       pick;
  logic [AW-1:0]       pick_pos;
  logic [EW-1:0]       pick_entry;
  logic [KEY_BITS-1:0] pick_key;
  logic                pop_stop;
  logic [PW-1:0]       nxt_lft;
  logic                pop_leaf;

  assign accept    = in_valid && in_ready;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);
  assign count_m1  = count - CW'(1);
  assign up        = (pos - AW'(1)) >> 1;
  assign up_parent = (up - AW'(1)) >> 1;
  assign key_a     = ram_rdata_a[KEY_BITS-1:0];
  assign key_b     = ram_rdata_b[KEY_BITS-1:0];
  assign push_stop = (key_a <= cur_key);

  assign lft        = PW'({pos, 1'b1});
  assign rgt        = lft + PW'(1);
  assign pick_right = (rgt < PW'(count)) && (key_b < key_a);
  assign pick       = pick_right ? rgt : lft;
  assign pick_pos   = pick[AW-1:0];
  assign pick_entry = pick_right ? ram_rdata_b : ram_rdata_a;
  assign pick_key   = pick_entry[KEY_BITS-1:0];
  assign pop_stop   = (pick_key >= cur_key);
  assign nxt_lft    = PW'({pick_pos, 1'b1});
  assign pop_leaf   = (nxt_lft >= PW'(count));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_PUSH) begin
            if (is_full) begin
              state_next = ST_DONE;
            end else if (is_empty) begin
              state_next = ST_PLACE;
            end else begin
              state_next = ST_PUSH_CMP;
            end
          end else begin
            if (is_empty || count == CW'(1)) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_POP_LAST;
            end
          end
        end
      end
      ST_PUSH_CMP: begin
        if (push_stop) begin
          state_next = ST_DONE;
        end else if (up == '0) begin
          state_next = ST_PLACE;
        end
      end
      ST_POP_LAST: begin
        if (count == CW'(1)) begin
          state_next = ST_PLACE;
        end else begin
          state_next = ST_POP_CMP;
        end
      end
      ST_POP_CMP: begin
        if (pop_stop) begin
          state_next = ST_DONE;
        end else if (pop_leaf) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = {cur_id, cur_key};
    ram_raddr_a = up_parent;
    ram_raddr_b = AW'(nxt_lft + PW'(1));
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_op == OP_PUSH) begin
          ram_raddr_a = AW'(count_m1 >> 1);
        end else begin
          ram_raddr_a = count_m1[AW-1:0];
        end
      end
      ST_PUSH_CMP: begin
        ram_we = 1'b1;
        if (!push_stop) begin
          ram_wdata = ram_rdata_a;
        end
      end
      ST_POP_LAST: begin
        ram_raddr_a = AW'(1);
        ram_raddr_b = AW'(2);
      end
      ST_POP_CMP: begin
        ram_we      = 1'b1;
        ram_raddr_a = nxt_lft[AW-1:0];
        if (!pop_stop) begin
          ram_wdata = pick_entry;
        end
      end
      ST_PLACE: ram_we = 1'b1;
      ST_DONE:  res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_op == OP_PUSH && !is_full) begin
          count <= count + CW'(1);
        end else if (in_op == OP_POP && !is_empty) begin
          count <= count_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we && ram_waddr == '0) begin
      root_id  <= ram_wdata[EW-1:KEY_BITS];
      root_key <= ram_wdata[KEY_BITS-1:0];
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          pid     <= '0;
          pkey    <= '0;
          status  <= STATUS_DONE;
          cur_id  <= in_id;
          cur_key <= in_key;
          pos     <= count[AW-1:0];
          if (in_op == OP_PUSH) begin
            if (is_full) begin
              status <= STATUS_FULL;
            end
          end else begin
            if (is_empty) begin
              status <= STATUS_EMPTY;
            end else begin
              pid  <= root_id;
              pkey <= root_key;
            end
          end
        end
      end
      ST_PUSH_CMP: begin
        if (!push_stop) begin
          pos <= up;
        end
      end
      ST_POP_LAST: begin
        cur_id  <= ram_rdata_a[EW-1:KEY_BITS];
        cur_key <= key_a;
        pos     <= '0;
      end
      ST_POP_CMP: begin
        if (!pop_stop) begin
          pos <= pick_pos;
        end
      end
      ST_PLACE: ;
      ST_DONE:  ;
      default: ;
    endcase
  end

  assign res_pid        = pid;
  assign res_pkey       = pkey;
  assign res_status     = status;
  assign res_count      = count;
  assign res_root_valid = !is_empty;
  assign res_root_key   = is_empty ? '0 : root_key;

endmodule

### tb/tb_binary_min_heap_queue.sv
// self-checking testbench of the binary min-heap queue: directed table, then random traffic
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int HELD_W = $clog2(CAPACITY_DEF + 1);
  localparam int IN_W = ((ID_BITS_DEF + KEY_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((ID_BITS_DEF + 2 * KEY_BITS_DEF + HELD_W + 1 + 7) / 8) * 8;
  localparam int PKEY_LSB = ID_BITS_DEF;
  localparam int HELD_LSB = PKEY_LSB + KEY_BITS_DEF;
  localparam int RVALID_BIT = HELD_LSB + HELD_W;
  localparam int RKEY_LSB = RVALID_BIT + 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_ROWS = 20;

  typedef struct packed {
    logic [ID_BITS_DEF-1:0]  popped_id;
    logic [KEY_BITS_DEF-1:0] popped_key;
    logic [1:0]              status;
    logic [HELD_W-1:0]       entries_held;
    logic                    root_valid;
    logic [KEY_BITS_DEF-1:0] root_key;
  } heap_result_t;

  typedef struct packed {
    logic                    op;
    logic [ID_BITS_DEF-1:0]  id;
    logic [KEY_BITS_DEF-1:0] key;
    logic                    has_res;
    heap_result_t            res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = OP_PUSH;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  // predictor state: heap contents and fill level
  logic [ID_BITS_DEF-1:0]  heap_ids [CAPACITY_DEF];
  logic [KEY_BITS_DEF-1:0] heap_keys [CAPACITY_DEF];
  int unsigned heap_fill = 0;

  heap_result_t awaited_results [$];
  heap_result_t got_res;
  heap_result_t want_res;
  directed_row_t dir_rows [NUM_ROWS];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 35;
  int recv_idle_pct = 71;

  binary_min_heap_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_binary_min_heap_queue: errors");
      $finish;
    end
  end

  // applies one operation to the predictor heap and returns its result
  function automatic heap_result_t apply_heap_op(input logic op,
                                                 input logic [ID_BITS_DEF-1:0] id,
                                                 input logic [KEY_BITS_DEF-1:0] key);
    heap_result_t r;
    int unsigned pos;
    int unsigned up;
    int unsigned lft;
    int unsigned pick;
    logic [ID_BITS_DEF-1:0] mv_id;
    logic [KEY_BITS_DEF-1:0] mv_key;
    r = '0;
    r.status = STATUS_DONE;
    if (op == OP_PUSH) begin
      if (heap_fill >= CAPACITY_DEF) begin
        r.status = STATUS_FULL;
      end else begin
        pos = heap_fill;
        heap_fill++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] <= key) break;
          heap_ids[pos] = heap_ids[up];
          heap_keys[pos] = heap_keys[up];
          pos = up;
        end
        heap_ids[pos] = id;
        heap_keys[pos] = key;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.popped_id = heap_ids[0];
        r.popped_key = heap_keys[0];
        heap_fill--;
        if (heap_fill != 0) begin
          mv_id = heap_ids[heap_fill];
          mv_key = heap_keys[heap_fill];
          pos = 0;
          forever begin
            lft = pos * 2 + 1;
            if (lft >= heap_fill) break;
            pick = lft;
            if (lft + 1 < heap_fill && heap_keys[lft+1] < heap_keys[lft]) pick = lft + 1;
            if (heap_keys[pick] >= mv_key) break;
            heap_ids[pos] = heap_ids[pick];
            heap_keys[pos] = heap_keys[pick];
            pos = pick;
          end
          heap_ids[pos] = mv_id;
          heap_keys[pos] = mv_key;
        end
      end
    end
    r.entries_held = heap_fill[HELD_W-1:0];
    r.root_valid = (heap_fill != 0);
    r.root_key = (heap_fill != 0) ? heap_keys[0] : '0;
    return r;
  endfunction

  function automatic logic [KEY_BITS_DEF-1:0] random_key();
    logic [KEY_BITS_DEF-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = KEY_BITS_DEF'($urandom_range(0, 7));
      4:          k = $urandom_range(0, 1) ? '1 : '0;
      default:    k = KEY_BITS_DEF'($urandom);
    endcase
    return k;
  endfunction

  function automatic logic [ID_BITS_DEF-1:0] random_id();
    logic [ID_BITS_DEF-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = ID_BITS_DEF'($urandom);
    endcase
    return v;
  endfunction

  // offers one transaction, waits for the handshake and records what it should return
  task automatic send_op(input logic op, input logic [ID_BITS_DEF-1:0] id,
                         input logic [KEY_BITS_DEF-1:0] key, input logic has_res,
                         input heap_result_t typed_res);
    heap_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(IN_W - ID_BITS_DEF - KEY_BITS_DEF){1'b0}}, key, id};
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_heap_op(op, id, key);
    awaited_results.push_back(has_res ? typed_res : predicted);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_run(input int count);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
      end
      send_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
              random_id(), random_key(), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.popped_id = m_axis_tdata[ID_BITS_DEF-1:0];
      got_res.popped_key = m_axis_tdata[PKEY_LSB +: KEY_BITS_DEF];
      got_res.status = m_axis_tuser;
      got_res.entries_held = m_axis_tdata[HELD_LSB +: HELD_W];
      got_res.root_valid = m_axis_tdata[RVALID_BIT];
      got_res.root_key = m_axis_tdata[RKEY_LSB +: KEY_BITS_DEF];
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transaction: id %h key %h st %0d n %0d rv %0d root %h",
                   got_res.popped_id, got_res.popped_key, got_res.status,
                   got_res.entries_held, got_res.root_valid, got_res.root_key);
        end
      end else begin
        want_res = awaited_results.pop_front();
        if (got_res.popped_id !== want_res.popped_id ||
            got_res.popped_key !== want_res.popped_key ||
            got_res.status !== want_res.status ||
            got_res.entries_held !== want_res.entries_held ||
            got_res.root_valid !== want_res.root_valid ||
            got_res.root_key !== want_res.root_key) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp id %h key %h st %0d n %0d rv %0d root %h",
                     want_res.popped_id, want_res.popped_key, want_res.status,
                     want_res.entries_held, want_res.root_valid, want_res.root_key);
            $display("          got id %h key %h st %0d n %0d rv %0d root %h",
                     got_res.popped_id, got_res.popped_key, got_res.status,
                     got_res.entries_held, got_res.root_valid, got_res.root_key);
          end
        end
      end
    end
  end

  initial begin
    // op, id, key, typed result flag, typed result
    dir_rows = '{
      '{OP_POP,  20'h00000, 16'h0000, 1'b1, '{20'h0, 16'h0, STATUS_EMPTY, 11'd0, 1'b0, 16'h0}},
      '{OP_PUSH, 20'hFFFFF, 16'hFFFF, 1'b1, '{20'h0, 16'h0, STATUS_DONE, 11'd1, 1'b1, 16'hFFFF}},
      '{OP_PUSH, 20'h00000, 16'h0000, 1'b1, '{20'h0, 16'h0, STATUS_DONE, 11'd2, 1'b1, 16'h0}},
      '{OP_PUSH, 20'h00001, 16'h0005, 1'b0, '0},
      '{OP_PUSH, 20'h00002, 16'h0005, 1'b0, '0},
      '{OP_PUSH, 20'h00003, 16'h0005, 1'b0, '0},
      // equal key below the root must not climb past it
      '{OP_PUSH, 20'h00004, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'hFFFFF, 16'hFFFF, 1'b1, '{20'h0, 16'h0, STATUS_EMPTY, 11'd0, 1'b0, 16'h0}},
      '{OP_PUSH, 20'hAAAAA, 16'h5555, 1'b0, '0},
      '{OP_PUSH, 20'h55555, 16'hAAAA, 1'b0, '0},
      '{OP_PUSH, 20'h12345, 16'h8000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0},
      '{OP_POP,  20'h00000, 16'h0000, 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].id, dir_rows[i].key, dir_rows[i].has_res,
              dir_rows[i].res);
    end
    drain();
    random_run(40);
    drain();
    sender_idle_pct = 71;
    recv_idle_pct = 35;
    random_run(40);
    drain();
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    random_run(40);
    // fill to capacity, overflow, then take some entries back out
    while (heap_fill < CAPACITY_DEF) send_op(OP_PUSH, random_id(), random_key(), 1'b0, '0);
    repeat (3) send_op(OP_PUSH, random_id(), random_key(), 1'b0, '0);
    repeat (20) send_op(OP_POP, random_id(), random_key(), 1'b0, '0);
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_binary_min_heap_queue: clean");
    end else begin
      $display("tb_binary_min_heap_queue: errors");
    end
    $finish;
  end

endmodule
